// ----- design/gblt_pkg.sv -----
// Types, codes and fixed constants shared by the glyph blitter.
package gblt_pkg;

    localparam int FONT_DEPTH  = 3072;
    localparam int FONT_ADDR_W = 12;
    localparam logic [7:0] FIRST_CODE = 8'h20;
    localparam logic [7:0] BYTE_ONES  = 8'hFF;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    localparam logic [1:0] CFG_GLYPH_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_GLYPH_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ADVANCE      = 2'd2;

    typedef struct packed {
        logic        op;
        logic [11:0] font_addr;
        logic [7:0]  font_data;
        logic [6:0]  pos_x;
        logic [5:0]  pos_y;
        logic [7:0]  char_code;
        logic        invert;
    } t_in_item;

    typedef struct packed {
        logic [10:0] fb_addr;
        logic [7:0]  or_mask;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_SCAN_RD,
        ST_SCAN_WT,
        ST_ROW_RD,
        ST_ROW_WT,
        ST_EMIT
    } t_state;

endpackage

// ----- design/glyph_blit_left_trimmed.sv -----
// Glyph blitter top level: font memory, trim scan and OR-write sequencer.
//
//  Channel | Direction | Handshake               | Payload
//  in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_ready| o_out_data (t_out_item)
//  cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// A load is taken while the sequencer is idle. A draw first scans every byte of the glyph
// for the trim, then per row fetches the row and emits its writes, all paced by the
// single registered read port of the font memory.
// Reset returns the sequencer to idle, clears the output valid flag and sets the configuration registers to 8.
// A stalled output transfer holds the sequencer in place; no input is taken during a draw.
module glyph_blit_left_trimmed
    import gblt_pkg::*;
#(
    parameter int GLYPH_COUNT = 96,
    parameter int MAX_ROWS    = 16,
    parameter int LINE_BYTES  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [4:0] i_cfg_data
);

    localparam int SPAN_W = $clog2(2 * MAX_ROWS * GLYPH_COUNT);
    localparam int ADDR_W = (SPAN_W > FONT_ADDR_W) ? SPAN_W : FONT_ADDR_W;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    t_state             r_state, n_state;
    logic [4:0]         r_gw, r_gh, r_adv;
    logic [7:0]         r_idx, n_idx;
    logic [2:0]         r_xo, n_xo;
    logic               r_inv, n_inv;
    logic [ADDR_W-1:0]  r_base, n_base;
    logic [ADDR_W-1:0]  r_row_base, n_row_base;
    logic [ROW_W-1:0]   r_row, n_row;
    logic               r_col, n_col;
    logic [4:0]         r_ofs, n_ofs;
    logic [7:0]         r_b0, n_b0, r_b1, n_b1;
    logic               r_j, n_j;
    logic               r_sub, n_sub;
    logic [10:0]        r_row_fb, n_row_fb;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic [7:0]         r_mem [FONT_DEPTH];
    logic [7:0]         r_rdata;
    logic               r_rd_oob;

    logic [4:0]         h_eff, hm1, full_ofs, ofs_upd;
    logic               wb2, code_ok, row_last, col_last, out_free, nb, found, mem_we;
    logic [ADDR_W-1:0]  rd_addr, wb_step;
    logic [7:0]         rd_byte, hi, lo, f, inv_mask;
    logic [15:0]        sh;
    logic [2:0]         lz;
    logic [4:0]         cand;
    logic [12:0]        prod;
    logic [13:0]        base_full;
    logic [15:0]        low_sh;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign h_eff    = (r_gh > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : r_gh;
    assign hm1      = h_eff - 5'd1;
    assign wb2      = (r_gw > 5'd8);
    assign wb_step  = ADDR_W'({wb2, ~wb2});
    assign full_ofs = wb2 ? 5'd16 : 5'd8;
    assign rd_addr  = r_row_base + ADDR_W'(r_col);
    assign rd_byte  = r_rd_oob ? 8'h00 : r_rdata;
    assign row_last = (5'(r_row) == hm1);
    assign col_last = (r_col == wb2);
    assign out_free = !r_out_valid || i_out_ready;
    assign code_ok  = (i_in_data.char_code >= FIRST_CODE) &&
                      ({1'b0, i_in_data.char_code} < 9'(int'(FIRST_CODE) + GLYPH_COUNT));
    assign mem_we   = i_in_valid && o_in_ready && (i_in_data.op == OP_LOAD) &&
                      (i_in_data.font_addr < 12'(FONT_DEPTH));
    assign prod      = 13'(h_eff) * 13'(r_idx);
    assign base_full = wb2 ? {prod, 1'b0} : {1'b0, prod};
    assign inv_mask  = (r_adv[2:0] == 3'd0) ? 8'h00 : ~(BYTE_ONES >> r_adv[2:0]);

    always_comb begin
        lz    = 3'd0;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found && rd_byte[7 - i]) begin
                lz    = 3'(i);
                found = 1'b1;
            end
        end
    end

    assign cand    = {1'b0, r_col, lz};
    assign ofs_upd = (found && (cand < r_ofs)) ? cand : r_ofs;

    assign nb = r_ofs[3] | r_j;
    assign hi = nb ? r_b1 : r_b0;
    assign lo = (!nb && wb2) ? r_b1 : 8'h00;
    assign sh = {hi, lo} << r_ofs[2:0];
    assign f  = (r_inv && (nb == wb2)) ? (sh[15:8] & inv_mask) : sh[15:8];
    assign low_sh = {f, 8'h00} >> r_xo;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_in_data.font_addr] <= i_in_data.font_data;
        end
        r_rdata  <= r_mem[rd_addr[FONT_ADDR_W-1:0]];
        r_rd_oob <= (rd_addr >= ADDR_W'(FONT_DEPTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_gw        <= 5'd8;
            r_gh        <= 5'd8;
            r_adv       <= 5'd8;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_GLYPH_WIDTH:  r_gw  <= i_cfg_data;
                    CFG_GLYPH_HEIGHT: r_gh  <= i_cfg_data;
                    CFG_ADVANCE:      r_adv <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_xo       <= n_xo;
        r_inv      <= n_inv;
        r_base     <= n_base;
        r_row_base <= n_row_base;
        r_row      <= n_row;
        r_col      <= n_col;
        r_ofs      <= n_ofs;
        r_b0       <= n_b0;
        r_b1       <= n_b1;
        r_j        <= n_j;
        r_sub      <= n_sub;
        r_row_fb   <= n_row_fb;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_xo        = r_xo;
        n_inv       = r_inv;
        n_base      = r_base;
        n_row_base  = r_row_base;
        n_row       = r_row;
        n_col       = r_col;
        n_ofs       = r_ofs;
        n_b0        = r_b0;
        n_b1        = r_b1;
        n_j         = r_j;
        n_sub       = r_sub;
        n_row_fb    = r_row_fb;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_data.op == OP_DRAW && code_ok &&
                    r_gw != 5'd0 && r_gh != 5'd0) begin
                    n_idx    = i_in_data.char_code - FIRST_CODE;
                    n_xo     = i_in_data.pos_x[2:0];
                    n_inv    = i_in_data.invert;
                    n_row_fb = 11'(i_in_data.pos_x[6:3]) +
                               11'(i_in_data.pos_y) * 11'(LINE_BYTES);
                    n_state  = ST_SETUP;
                end
            end
            ST_SETUP: begin
                n_base     = ADDR_W'(base_full);
                n_row_base = ADDR_W'(base_full);
                n_row      = '0;
                n_col      = 1'b0;
                n_ofs      = full_ofs;
                n_state    = ST_SCAN_RD;
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_WT;
            end
            ST_SCAN_WT: begin
                n_ofs   = ofs_upd;
                n_state = ST_SCAN_RD;
                if (col_last) begin
                    n_col = 1'b0;
                    if (row_last) begin
                        n_row_base = r_base;
                        n_row      = '0;
                        n_state    = ST_ROW_RD;
                        if (ofs_upd == full_ofs) begin
                            n_ofs = 5'd0;
                        end
                    end else begin
                        n_row      = r_row + ROW_W'(1);
                        n_row_base = r_row_base + wb_step;
                    end
                end else begin
                    n_col = 1'b1;
                end
            end
            ST_ROW_RD: begin
                n_state = ST_ROW_WT;
            end
            ST_ROW_WT: begin
                if (r_col) begin
                    n_b1 = r_inv ? ~rd_byte : rd_byte;
                end else begin
                    n_b0 = r_inv ? ~rd_byte : rd_byte;
                end
                if (col_last) begin
                    n_col   = 1'b0;
                    n_j     = 1'b0;
                    n_sub   = 1'b0;
                    n_state = ST_EMIT;
                end else begin
                    n_col   = 1'b1;
                    n_state = ST_ROW_RD;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out.fb_addr = r_row_fb + 11'(r_j) + 11'(r_sub);
                    n_out.or_mask = r_sub ? low_sh[7:0] : (f >> r_xo);
                    n_out.last    = row_last && (nb == wb2) && r_sub;
                    if (!r_sub) begin
                        n_sub = 1'b1;
                    end else begin
                        n_sub = 1'b0;
                        if (nb == wb2) begin
                            if (row_last) begin
                                n_state = ST_IDLE;
                            end else begin
                                n_row      = r_row + ROW_W'(1);
                                n_row_base = r_row_base + wb_step;
                                n_row_fb   = r_row_fb + 11'(LINE_BYTES);
                                n_state    = ST_ROW_RD;
                            end
                        end else begin
                            n_j = 1'b1;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule
